// ===== src/skt_pkg.sv =====
// Shared field widths, operation codes and status codes for the sorted key table.
package skt_pkg;

	// Item field widths
	localparam int OP_W     = 2;
	localparam int KEY_W    = 56;
	localparam int PAY_W    = 64;
	localparam int GRADE_W  = 8;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 8;

	// Packed stream widths, whole bytes
	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 80;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== src/sorted_key_table.sv =====
// Sorted key table: ordered entry store with insert, delete, lookup and modify.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  --------+-----+------------------------------------------------------+--------
//  s_axis  | in  | key[55:0], payload[119:56], grade[127:120]           | op
//  m_axis  | out | found_payload[63:0], found_grade[71:64], total[79:72]| status
//
// One item at a time. The search reads one entry per cycle and stops at the first key not
// below the request; insert or delete then moves one entry per cycle through the same port.
// Search and move together touch at most n+1 entries for n held, followed by the decision,
// the new-entry write and the result loading.
// Reset clears the entry count and the control state; table contents are not cleared.
// A held result lets the next item in; the sequencer waits only while both results are held.
module sorted_key_table #(
	parameter int TABLE_DEPTH = 128,
	parameter int KEY_CHARS   = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [skt_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // key, payload, grade
	input  logic [skt_pkg::OP_W-1:0]       s_axis_tuser,  // op
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [skt_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // found_payload, found_grade, entry_total
	output logic [skt_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);

	localparam int KW = 8 * KEY_CHARS;
	localparam int WW = KW + skt_pkg::PAY_W + skt_pkg::GRADE_W;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SRCH   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHUP   = 3'd3;
	localparam logic [2:0] S_WRNEW  = 3'd4;
	localparam logic [2:0] S_SHDN   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q, state_d;

	// Request registers
	logic [skt_pkg::OP_W-1:0]    op_q;
	logic [KW-1:0]               key_q;
	logic [skt_pkg::PAY_W-1:0]   pay_q;
	logic [skt_pkg::GRADE_W-1:0] grade_q;

	// Counters and search outcome
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [CW-1:0] j_q, j_d;
	logic          hit_q, hit_d;

	// Result being built and output register
	logic [skt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
	logic [skt_pkg::PAY_W-1:0]    res_pay_q, res_pay_d;
	logic [skt_pkg::GRADE_W-1:0]  res_grade_q, res_grade_d;
	logic                         out_valid_q;
	logic [skt_pkg::STATUS_W-1:0] out_status_q;
	logic [skt_pkg::PAY_W-1:0]    out_pay_q;
	logic [skt_pkg::GRADE_W-1:0]  out_grade_q;
	logic [skt_pkg::TOTAL_W-1:0]  out_total_q;
	logic                         out_load;

	// Table memory, one port read and one port write per cycle
	logic [WW-1:0] mem [TABLE_DEPTH];
	logic [WW-1:0] rd_q;
	logic          rd_en, wr_en;
	logic [CW-1:0] rd_addr, wr_addr;
	logic [WW-1:0] wr_data;

	// Fields of the word read back
	logic [KW-1:0]               rd_key;
	logic [skt_pkg::PAY_W-1:0]   rd_pay;
	logic [skt_pkg::GRADE_W-1:0] rd_grade;
	logic                        key_less, last_entry;

	logic                        in_fire;
	logic [KW-1:0]               in_key_norm;
	logic [CW+skt_pkg::TOTAL_W-1:0] total_ext;

	// Cut key to KEY_CHARS bytes and clear every byte from the first zero byte on
	function automatic logic [KW-1:0] norm_key(input logic [skt_pkg::KEY_W-1:0] raw);
		logic [63:0]   wide;
		logic [KW-1:0] res;
		logic          live;
		wide = 64'(raw);
		res  = '0;
		live = 1'b1;
		for (int c = 0; c < KEY_CHARS; c++) begin
			if (wide[8*(KEY_CHARS-1-c) +: 8] == 8'd0)
				live = 1'b0;
			if (live)
				res[8*(KEY_CHARS-1-c) +: 8] = wide[8*(KEY_CHARS-1-c) +: 8];
		end
		return res;
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_key_norm   = norm_key(s_axis_tdata[skt_pkg::KEY_W-1:0]);

	assign rd_key     = rd_q[WW-1 -: KW];
	assign rd_pay     = rd_q[skt_pkg::GRADE_W +: skt_pkg::PAY_W];
	assign rd_grade   = rd_q[skt_pkg::GRADE_W-1:0];
	assign key_less   = (rd_key < key_q);
	assign last_entry = ((idx_q + CW'(1)) == cnt_q);

	// Hold the request fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= s_axis_tuser;
			key_q   <= in_key_norm;
			pay_q   <= s_axis_tdata[skt_pkg::KEY_W +: skt_pkg::PAY_W];
			grade_q <= s_axis_tdata[skt_pkg::KEY_W+skt_pkg::PAY_W +: skt_pkg::GRADE_W];
		end
	end

	// Sequencer: search, decide, move entries, finish
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		j_d          = j_q;
		hit_d        = hit_q;
		res_status_d = res_status_q;
		res_pay_d    = res_pay_q;
		res_grade_d  = res_grade_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = rd_q;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					idx_d        = '0;
					res_status_d = skt_pkg::ST_OK;
					res_pay_d    = '0;
					res_grade_d  = '0;
					if (cnt_q == '0) begin
						pos_d   = '0;
						hit_d   = 1'b0;
						state_d = S_DECIDE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (!key_less) begin
					pos_d   = idx_q;
					hit_d   = (rd_key == key_q);
					state_d = S_DECIDE;
				end else if (last_entry) begin
					pos_d   = cnt_q;
					hit_d   = 1'b0;
					state_d = S_DECIDE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + CW'(1);
					idx_d   = idx_q + CW'(1);
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				unique case (op_q)
					skt_pkg::OP_INSERT: begin
						if (hit_q) begin
							res_status_d = skt_pkg::ST_DUPLICATE;
						end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
							res_status_d = skt_pkg::ST_FULL;
						end else if (cnt_q > pos_q) begin
							rd_en   = 1'b1;
							rd_addr = cnt_q - CW'(1);
							j_d     = cnt_q;
							state_d = S_SHUP;
						end else begin
							state_d = S_WRNEW;
						end
					end
					skt_pkg::OP_DELETE: begin
						if (!hit_q) begin
							res_status_d = skt_pkg::ST_NOT_FOUND;
						end else if ((pos_q + CW'(1)) < cnt_q) begin
							rd_en   = 1'b1;
							rd_addr = pos_q + CW'(1);
							j_d     = pos_q;
							state_d = S_SHDN;
						end else begin
							cnt_d = cnt_q - CW'(1);
						end
					end
					skt_pkg::OP_LOOKUP: begin
						if (!hit_q) begin
							res_status_d = skt_pkg::ST_NOT_FOUND;
						end else begin
							res_pay_d   = rd_pay;
							res_grade_d = rd_grade;
						end
					end
					skt_pkg::OP_MODIFY: begin
						if (!hit_q) begin
							res_status_d = skt_pkg::ST_NOT_FOUND;
						end else begin
							wr_en   = 1'b1;
							wr_addr = pos_q;
							wr_data = {key_q, pay_q, grade_q};
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SHUP: begin
				// Move entry j-1 up to j
				wr_en   = 1'b1;
				wr_addr = j_q;
				if ((j_q - CW'(1)) > pos_q) begin
					rd_en   = 1'b1;
					rd_addr = j_q - CW'(2);
					j_d     = j_q - CW'(1);
				end else begin
					state_d = S_WRNEW;
				end
			end
			S_WRNEW: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = {key_q, pay_q, grade_q};
				cnt_d   = cnt_q + CW'(1);
				state_d = S_DONE;
			end
			S_SHDN: begin
				// Move entry j+1 down to j
				wr_en   = 1'b1;
				wr_addr = j_q;
				if ((j_q + CW'(2)) < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = j_q + CW'(2);
					j_d     = j_q + CW'(1);
				end else begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		j_q          <= j_d;
		hit_q        <= hit_d;
		res_status_q <= res_status_d;
		res_pay_q    <= res_pay_d;
		res_grade_q  <= res_grade_d;
	end

	// Table memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr[AW-1:0]] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr[AW-1:0]];
	end

	// Output register
	assign total_ext = {{skt_pkg::TOTAL_W{1'b0}}, cnt_q};

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_pay_q    <= res_pay_q;
			out_grade_q  <= res_grade_q;
			out_total_q  <= total_ext[skt_pkg::TOTAL_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_total_q, out_grade_q, out_pay_q};

	// Checks on the sequencer
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_srch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (idx_q < cnt_q))
		else $error("search index beyond stored entries");

	a_shup_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHUP) |-> ((j_q > pos_q) && (j_q <= cnt_q) && (cnt_q < CW'(TABLE_DEPTH))))
		else $error("insert shift outside its range");

	a_shdn_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHDN) |-> ((j_q + CW'(1)) < cnt_q))
		else $error("delete shift outside its range");

endmodule

// ===== bench/tb_sorted_key_table.sv =====
// Self-checking testbench for the sorted key table: directed rows, then random traffic.
module tb_sorted_key_table;

	localparam int TABLE_DEPTH = 128;
	localparam int HOLD_CYCLES = 1200;
	localparam int TAIL_CYCLES = 600;
	localparam int unsigned CYCLE_LIMIT = 2_500_000;

	typedef struct packed {
		logic [skt_pkg::STATUS_W-1:0] status;
		logic [skt_pkg::PAY_W-1:0]    fpay;
		logic [skt_pkg::GRADE_W-1:0]  fgrade;
		logic [skt_pkg::TOTAL_W-1:0]  total;
	} outcome_t;

	typedef struct packed {
		logic [skt_pkg::OP_W-1:0]    op;
		logic [skt_pkg::KEY_W-1:0]   key;
		logic [skt_pkg::PAY_W-1:0]   pay;
		logic [skt_pkg::GRADE_W-1:0] grade;
		logic                        typed;
		outcome_t                    want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_valid = 1'b0;
	logic s_ready;
	logic [skt_pkg::S_TDATA_W-1:0] s_data = '0;         // key, payload, grade
	logic [skt_pkg::OP_W-1:0] s_op = skt_pkg::OP_LOOKUP; // op
	logic m_valid;
	logic m_ready = 1'b0;
	logic [skt_pkg::M_TDATA_W-1:0] m_data;  // found_payload, found_grade, entry_total
	logic [skt_pkg::STATUS_W-1:0] m_status; // status

	// Shadow copy of the table contents
	logic [skt_pkg::KEY_W-1:0]   shadow_key   [TABLE_DEPTH];
	logic [skt_pkg::PAY_W-1:0]   shadow_pay   [TABLE_DEPTH];
	logic [skt_pkg::GRADE_W-1:0] shadow_grade [TABLE_DEPTH];
	int shadow_count = 0;

	outcome_t awaited [$];
	outcome_t head;
	int mismatches = 0;
	int results_seen = 0;
	int unsigned cycle_count = 0;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;

	// Directed rows, starting from an empty table
	plan_row_t plan [24] = '{
		'{skt_pkg::OP_LOOKUP, 56'h41000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_NOT_FOUND, 64'h0, 8'h0, 8'd0}},
		'{skt_pkg::OP_DELETE, 56'h41000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_NOT_FOUND, 64'h0, 8'h0, 8'd0}},
		'{skt_pkg::OP_MODIFY, 56'h41000000000000, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1,
			'{skt_pkg::ST_NOT_FOUND, 64'h0, 8'h0, 8'd0}},
		'{skt_pkg::OP_INSERT, 56'hFFFFFFFFFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd1}},
		'{skt_pkg::OP_INSERT, 56'hFFFFFFFFFFFFFF, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_DUPLICATE, 64'h0, 8'h0, 8'd1}},
		'{skt_pkg::OP_LOOKUP, 56'hFFFFFFFFFFFFFF, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'd1}},
		'{skt_pkg::OP_INSERT, 56'h00000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd2}},
		'{skt_pkg::OP_LOOKUP, 56'h00000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd2}},
		'{skt_pkg::OP_INSERT, 56'h41004243444546, 64'h0123_4567_89AB_CDEF, 8'h5A, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd3}},
		'{skt_pkg::OP_LOOKUP, 56'h41000000000000, 64'h0, 8'h00, 1'b0, '0},
		'{skt_pkg::OP_INSERT, 56'h4100FFFFFFFFFF, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_DUPLICATE, 64'h0, 8'h0, 8'd3}},
		'{skt_pkg::OP_MODIFY, 56'h41000000000000, 64'hFEDC_BA98_7654_3210, 8'hA5, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd3}},
		'{skt_pkg::OP_LOOKUP, 56'h41007F00000000, 64'h0, 8'h00, 1'b0, '0},
		'{skt_pkg::OP_INSERT, 56'h41424300000000, 64'h5555_5555_5555_5555, 8'h55, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd4}},
		'{skt_pkg::OP_INSERT, 56'h01000000000000, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd5}},
		'{skt_pkg::OP_LOOKUP, 56'h41424300000000, 64'h0, 8'h00, 1'b0, '0},
		'{skt_pkg::OP_DELETE, 56'hFFFFFFFFFFFFFF, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd4}},
		'{skt_pkg::OP_LOOKUP, 56'hFFFFFFFFFFFFFF, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_NOT_FOUND, 64'h0, 8'h0, 8'd4}},
		'{skt_pkg::OP_DELETE, 56'h00000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd3}},
		'{skt_pkg::OP_DELETE, 56'h41000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd2}},
		'{skt_pkg::OP_MODIFY, 56'h41000000000000, 64'h1, 8'h01, 1'b1,
			'{skt_pkg::ST_NOT_FOUND, 64'h0, 8'h0, 8'd2}},
		'{skt_pkg::OP_DELETE, 56'h01000000000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd1}},
		'{skt_pkg::OP_DELETE, 56'h41424300000000, 64'h0, 8'h00, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd0}},
		'{skt_pkg::OP_INSERT, 56'h7F7F7F7F7F7F7F, 64'h8000_0000_0000_0001, 8'h80, 1'b1,
			'{skt_pkg::ST_OK, 64'h0, 8'h0, 8'd1}}
	};

	sorted_key_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_op),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_status)
	);

	always #10 clk = ~clk;

	// Cut the key at its first zero byte, as a string ends there
	function automatic logic [skt_pkg::KEY_W-1:0] string_key(logic [skt_pkg::KEY_W-1:0] raw);
		logic [skt_pkg::KEY_W-1:0] k;
		bit ended;
		k = '0;
		ended = 1'b0;
		for (int c = skt_pkg::KEY_W / 8 - 1; c >= 0; c--) begin
			if (raw[c*8 +: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				k[c*8 +: 8] = raw[c*8 +: 8];
		end
		return k;
	endfunction

	// Apply one operation to the shadow table and work out its outcome
	function automatic outcome_t table_operation(logic [skt_pkg::OP_W-1:0] op,
			logic [skt_pkg::KEY_W-1:0] raw, logic [skt_pkg::PAY_W-1:0] pay,
			logic [skt_pkg::GRADE_W-1:0] grade);
		outcome_t res;
		logic [skt_pkg::KEY_W-1:0] k;
		int pos;
		bit hit;
		res = '0;
		k = string_key(raw);
		pos = 0;
		while (pos < shadow_count && shadow_key[pos] < k)
			pos++;
		hit = (pos < shadow_count) && (shadow_key[pos] == k);
		case (op)
			skt_pkg::OP_INSERT: begin
				if (hit) begin
					res.status = skt_pkg::ST_DUPLICATE;
				end else if (shadow_count >= TABLE_DEPTH) begin
					res.status = skt_pkg::ST_FULL;
				end else begin
					for (int j = shadow_count; j > pos; j--) begin
						shadow_key[j]   = shadow_key[j-1];
						shadow_pay[j]   = shadow_pay[j-1];
						shadow_grade[j] = shadow_grade[j-1];
					end
					shadow_key[pos]   = k;
					shadow_pay[pos]   = pay;
					shadow_grade[pos] = grade;
					shadow_count++;
				end
			end
			skt_pkg::OP_DELETE: begin
				if (!hit) begin
					res.status = skt_pkg::ST_NOT_FOUND;
				end else begin
					for (int j = pos; j + 1 < shadow_count; j++) begin
						shadow_key[j]   = shadow_key[j+1];
						shadow_pay[j]   = shadow_pay[j+1];
						shadow_grade[j] = shadow_grade[j+1];
					end
					shadow_count--;
				end
			end
			skt_pkg::OP_LOOKUP: begin
				if (!hit) begin
					res.status = skt_pkg::ST_NOT_FOUND;
				end else begin
					res.fpay   = shadow_pay[pos];
					res.fgrade = shadow_grade[pos];
				end
			end
			default: begin
				if (!hit) begin
					res.status = skt_pkg::ST_NOT_FOUND;
				end else begin
					shadow_pay[pos]   = pay;
					shadow_grade[pos] = grade;
				end
			end
		endcase
		res.total = shadow_count[skt_pkg::TOTAL_W-1:0];
		return res;
	endfunction

	// Draw a key: fresh and wide, one already held, or a short one from a small alphabet
	function automatic logic [skt_pkg::KEY_W-1:0] pick_key(bit fresh);
		logic [63:0] wide;
		logic [skt_pkg::KEY_W-1:0] k;
		int sel;
		int chars;
		bit ended;
		wide = {$urandom, $urandom};
		sel = fresh ? 9 : $urandom_range(0, 9);
		if (sel < 5 && shadow_count > 0) begin
			k = shadow_key[$urandom_range(0, shadow_count - 1)];
		end else if (sel < 8) begin
			k = '0;
			chars = $urandom_range(0, 3);
			for (int c = 0; c < chars; c++)
				k[skt_pkg::KEY_W-1-8*c -: 8] = 8'h61 + 8'($urandom_range(0, 3));
		end else begin
			return wide[skt_pkg::KEY_W-1:0];
		end
		// Fill the bytes past the terminator with noise; they must not matter
		if ($urandom_range(0, 3) == 0) begin
			ended = 1'b0;
			for (int c = skt_pkg::KEY_W / 8 - 1; c >= 0; c--) begin
				if (ended)
					k[c*8 +: 8] = 8'($urandom);
				else if (k[c*8 +: 8] == 8'h00)
					ended = 1'b1;
			end
		end
		return k;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("ERROR result %0d %s: got %0h, expected %0h", results_seen, field, got, want);
		mismatches++;
	endtask

	// Offer one item after a random gap and hold it until taken
	task automatic offer_item(logic [skt_pkg::OP_W-1:0] op, logic [skt_pkg::KEY_W-1:0] key,
			logic [skt_pkg::PAY_W-1:0] pay, logic [skt_pkg::GRADE_W-1:0] grade,
			logic typed, outcome_t want);
		int gap;
		outcome_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= {grade, pay, key};
		s_op    <= op;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		predicted = table_operation(op, key, pay, grade);
		awaited.push_back(typed ? want : predicted);
	endtask

	task automatic offer_random(logic [skt_pkg::OP_W-1:0] op, bit fresh);
		offer_item(op, pick_key(fresh), {$urandom, $urandom}, 8'($urandom), 1'b0, '0);
	endtask

	// Drop valid and hold until every awaited result is in
	task automatic wait_for_results();
		s_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited.size() != 0);
	endtask

	// Receiver: random stalls, with one long hold-off on request
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				m_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_ready <= 1'b1;
			@(posedge clk);
			while (!m_valid)
				@(posedge clk);
		end
	end

	// Compare each result with the oldest awaited outcome
	always @(posedge clk) begin
		if (m_valid && m_ready) begin
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch("result with none awaited, status", 64'(m_status), 64'd0);
			end else begin
				head = awaited.pop_front();
				if (m_status !== head.status)
					report_mismatch("status", 64'(m_status), 64'(head.status));
				if (m_data[63:0] !== head.fpay)
					report_mismatch("found_payload", m_data[63:0], head.fpay);
				if (m_data[71:64] !== head.fgrade)
					report_mismatch("found_grade", 64'(m_data[71:64]), 64'(head.fgrade));
				if (m_data[79:72] !== head.total)
					report_mismatch("entry_total", 64'(m_data[79:72]), 64'(head.total));
			end
		end
	end

	// Give up on a hung block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int guard;
		int r;
		logic [skt_pkg::OP_W-1:0] op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		foreach (plan[i])
			offer_item(plan[i].op, plan[i].key, plan[i].pay, plan[i].grade,
				plan[i].typed, plan[i].want);

		// Fill the table to the top, mostly with fresh keys
		guard = 0;
		while (shadow_count < TABLE_DEPTH && guard < 400) begin
			offer_random(skt_pkg::OP_INSERT, $urandom_range(0, 9) != 0);
			guard++;
		end

		// Hit the full table, then read and rewrite it while full
		repeat (12) offer_random(skt_pkg::OP_INSERT, $urandom_range(0, 1) == 0);
		repeat (12) offer_random($urandom_range(0, 1) ? skt_pkg::OP_LOOKUP : skt_pkg::OP_MODIFY,
			1'b0);

		// Let everything drain, then make the receiver sit back while items keep coming
		wait_for_results();
		hold_request = 1'b1;

		// Mixed traffic, steered to keep the table at middling sizes
		for (int i = 0; i < 1330; i++) begin
			no_idle = ((i / 60) % 4 == 3);
			r = $urandom_range(0, 99);
			if (shadow_count < 40)
				op = (r < 45) ? skt_pkg::OP_INSERT : (r < 60) ? skt_pkg::OP_DELETE :
					(r < 80) ? skt_pkg::OP_LOOKUP : skt_pkg::OP_MODIFY;
			else if (shadow_count > 110)
				op = (r < 20) ? skt_pkg::OP_INSERT : (r < 55) ? skt_pkg::OP_DELETE :
					(r < 80) ? skt_pkg::OP_LOOKUP : skt_pkg::OP_MODIFY;
			else
				op = (r < 30) ? skt_pkg::OP_INSERT : (r < 55) ? skt_pkg::OP_DELETE :
					(r < 80) ? skt_pkg::OP_LOOKUP : skt_pkg::OP_MODIFY;
			offer_random(op, 1'b0);
		end
		no_idle = 1'b0;

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
